// File: src/cts_pkg.sv
// shared types, codes and constants of the conformer transition selector
`timescale 1ns / 1ps
package cts_pkg;
	localparam int CoordW = 24;
	localparam int FracW = 16;
	localparam int WeightW = FracW + 1;
	localparam int RmsdW = 32;
	localparam int SumW = 64;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_COMPUTE = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_COMPUTE = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic [4:0] REG_CONFORMER_COUNT = 5'd0;
	localparam logic [4:0] REG_ATOM_COUNT = 5'd1;

	typedef struct packed {
		logic [1:0] operation;
		logic [3:0] load_conformer;
		logic [11:0] load_atom;
		logic signed [CoordW-1:0] pos_x;
		logic signed [CoordW-1:0] pos_y;
		logic signed [CoordW-1:0] pos_z;
		logic [4:0] current_conformer;
		logic [15:0] random_fraction;
	} item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [4:0] next_conformer;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PAIR,
		ST_ATOM_RD,
		ST_ATOM_WAIT,
		ST_AXIS,
		ST_DIV,
		ST_SQRT,
		ST_RMSD_WR,
		ST_PAIR_NEXT,
		ST_W_RD,
		ST_W_WAIT,
		ST_W_DIV,
		ST_W_WR,
		ST_DIAG_DIV,
		ST_DIAG_WR,
		ST_ROW_NEXT,
		ST_Q_SUM_RD,
		ST_Q_SUM_ACC,
		ST_Q_MUL,
		ST_Q_WALK_RD,
		ST_Q_WALK_CMP,
		ST_DONE
	} state_t;

	// controller commands to the datapath
	typedef struct packed {
		logic capture;
		logic load_wr;
		logic pair_init;
		logic atom_rd;
		logic axis_acc;
		logic div_start;
		logic sqrt_start;
		logic rmsd_wr;
		logic pair_next;
		logic w_rd;
		logic w_div_start;
		logic w_wr;
		logic diag_div_start;
		logic diag_wr;
		logic row_next;
		logic q_init;
		logic q_rd;
		logic q_sum_acc;
		logic q_mul;
		logic q_walk_acc;
		logic done;
	} cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic axis_last;
		logic atom_last;
		logic pair_last;
		logic col_last;
		logic row_last;
		logic unit_busy;
		logic single;
		logic q_bad;
		logic q_hit;
		logic q_col_last;
	} status_t;
endpackage

// File: src/conformer_transition_selector_core.sv
// top level of the conformer transition selector
`timescale 1ns / 1ps
//
// channel  | signals                          | direction
// command  | start, busy, item                | in (start), out (busy)
// result   | done, result                     | out, one cycle strobe
// config   | cfg_we, cfg_index, cfg_data      | in, plain write
//
// query: the weight row of conformers in use is summed, then walked up to the first hit.
// compute: per pair each atom is read, waited on and summed over its three axes, then
// the shared 64-bit divider and the 32-step square root run; the divider then forms
// each weight.
// reset idles the controller and sets the config registers to 1; the stores start undefined.
// results cannot be stalled: done is high for exactly one cycle.
module conformer_transition_selector_core #(
	parameter int MAX_CONFORMERS = 16,
	parameter int MAX_ATOMS = 4096,
	parameter int WEIGHT_FRACTION_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input cts_pkg::item_t item,
	output logic done,
	output cts_pkg::result_t result,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [12:0] cfg_data
);
	cts_pkg::cmd_t cmd;
	cts_pkg::status_t status;
	logic ctrl_busy;
	logic [4:0] conformer_count_q;
	logic [12:0] atom_count_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conformer_count_q <= 5'd1;
			atom_count_q <= 13'd1;
		end else if (cfg_we) begin
			if (cfg_index == cts_pkg::REG_CONFORMER_COUNT[0:0]) begin
				conformer_count_q <= cfg_data[4:0];
			end else begin
				atom_count_q <= cfg_data;
			end
		end
	end

	cts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .operation(item.operation),
		.status(status), .cmd(cmd), .busy(ctrl_busy)
	);

	cts_datapath #(
		.MAX_CONFORMERS(MAX_CONFORMERS), .MAX_ATOMS(MAX_ATOMS),
		.WEIGHT_FRACTION_BITS(WEIGHT_FRACTION_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .conformer_count(conformer_count_q),
		.atom_count(atom_count_q), .cmd(cmd), .status(status), .result(result)
	);

	assign busy = ctrl_busy;
	assign done = cmd.done;
endmodule

// File: src/cts_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module cts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// File: src/cts_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module cts_divider #(
	parameter int W = 64
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [W-1:0] dividend,
	input logic [W-1:0] divisor,
	output logic busy,
	output logic [W-1:0] quotient
);
	localparam int CntW = $clog2(W + 1);
	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] div_q;
	logic [CntW-1:0] cnt_q;
	logic [W:0] trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, div_q};
	assign busy = (cnt_q != '0);
	assign quotient = quo_q;

	// shift and subtract step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

// File: src/cts_sqrt.sv
// digit-by-digit integer square root, one result bit per cycle
`timescale 1ns / 1ps
module cts_sqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] radicand,
	output logic busy,
	output logic [31:0] root
);
	logic [63:0] v_q;
	logic [65:0] rem_q;
	logic [31:0] r_q;
	logic [5:0] cnt_q;
	logic [65:0] rem_sh;
	logic [65:0] trial;

	assign rem_sh = {rem_q[63:0], v_q[63:62]};
	assign trial = rem_sh - {32'd0, r_q, 2'b01};
	assign busy = (cnt_q != '0);
	assign root = r_q;

	// two radicand bits per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			rem_q <= '0;
			r_q <= '0;
		end else if (busy) begin
			v_q <= {v_q[61:0], 2'b00};
			if (!trial[65]) begin
				rem_q <= trial;
				r_q <= {r_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				r_q <= {r_q[30:0], 1'b0};
			end
		end
	end
endmodule

// File: src/cts_ctrl.sv
// controller state machine of the conformer transition selector
`timescale 1ns / 1ps
module cts_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] operation,
	input cts_pkg::status_t status,
	output cts_pkg::cmd_t cmd,
	output logic busy
);
	cts_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cts_pkg::ST_IDLE: begin
				if (start) begin
					case (operation)
						cts_pkg::OP_LOAD: state_d = cts_pkg::ST_LOAD;
						cts_pkg::OP_COMPUTE: state_d = cts_pkg::ST_PAIR;
						cts_pkg::OP_QUERY: state_d = cts_pkg::ST_Q_SUM_RD;
						default: state_d = cts_pkg::ST_DONE;
					endcase
				end
			end
			cts_pkg::ST_LOAD: state_d = cts_pkg::ST_DONE;
			cts_pkg::ST_PAIR: begin
				state_d = status.pair_last ? cts_pkg::ST_W_RD : cts_pkg::ST_ATOM_RD;
			end
			cts_pkg::ST_ATOM_RD: state_d = cts_pkg::ST_ATOM_WAIT;
			cts_pkg::ST_ATOM_WAIT: state_d = cts_pkg::ST_AXIS;
			cts_pkg::ST_AXIS: begin
				if (status.axis_last) begin
					state_d = status.atom_last ? cts_pkg::ST_DIV : cts_pkg::ST_ATOM_RD;
				end
			end
			cts_pkg::ST_DIV: state_d = cts_pkg::ST_SQRT;
			cts_pkg::ST_SQRT: begin
				if (!status.unit_busy) begin
					state_d = cts_pkg::ST_RMSD_WR;
				end
			end
			cts_pkg::ST_RMSD_WR: begin
				if (!status.unit_busy) begin
					state_d = cts_pkg::ST_PAIR_NEXT;
				end
			end
			cts_pkg::ST_PAIR_NEXT: state_d = cts_pkg::ST_PAIR;
			cts_pkg::ST_W_RD: begin
				if (status.single) begin
					state_d = cts_pkg::ST_DIAG_WR;
				end else begin
					state_d = cts_pkg::ST_W_WAIT;
				end
			end
			cts_pkg::ST_W_WAIT: state_d = cts_pkg::ST_W_DIV;
			cts_pkg::ST_W_DIV: begin
				if (!status.unit_busy) begin
					state_d = cts_pkg::ST_W_WR;
				end
			end
			cts_pkg::ST_W_WR: begin
				if (!status.unit_busy) begin
					state_d = status.col_last ? cts_pkg::ST_DIAG_DIV : cts_pkg::ST_W_RD;
				end
			end
			cts_pkg::ST_DIAG_DIV: state_d = cts_pkg::ST_DIAG_WR;
			cts_pkg::ST_DIAG_WR: begin
				if (!status.unit_busy) begin
					state_d = cts_pkg::ST_ROW_NEXT;
				end
			end
			cts_pkg::ST_ROW_NEXT: begin
				state_d = status.row_last ? cts_pkg::ST_DONE : cts_pkg::ST_W_RD;
			end
			cts_pkg::ST_Q_SUM_RD: begin
				state_d = status.q_bad ? cts_pkg::ST_DONE : cts_pkg::ST_Q_SUM_ACC;
			end
			cts_pkg::ST_Q_SUM_ACC: begin
				state_d = status.q_col_last ? cts_pkg::ST_Q_MUL : cts_pkg::ST_Q_SUM_ACC;
			end
			cts_pkg::ST_Q_MUL: state_d = cts_pkg::ST_Q_WALK_RD;
			cts_pkg::ST_Q_WALK_RD: state_d = cts_pkg::ST_Q_WALK_CMP;
			cts_pkg::ST_Q_WALK_CMP: begin
				if (status.q_hit || status.q_col_last) begin
					state_d = cts_pkg::ST_DONE;
				end
			end
			cts_pkg::ST_DONE: state_d = cts_pkg::ST_IDLE;
			default: state_d = cts_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		busy = (state_q != cts_pkg::ST_IDLE);
		case (state_q)
			cts_pkg::ST_IDLE: cmd.capture = start;
			cts_pkg::ST_LOAD: cmd.load_wr = 1'b1;
			cts_pkg::ST_PAIR: cmd.pair_init = 1'b1;
			cts_pkg::ST_ATOM_RD: cmd.atom_rd = 1'b1;
			cts_pkg::ST_AXIS: cmd.axis_acc = 1'b1;
			cts_pkg::ST_DIV: cmd.div_start = 1'b1;
			cts_pkg::ST_SQRT: cmd.sqrt_start = !status.unit_busy;
			cts_pkg::ST_RMSD_WR: cmd.rmsd_wr = !status.unit_busy;
			cts_pkg::ST_PAIR_NEXT: cmd.pair_next = 1'b1;
			cts_pkg::ST_W_RD: cmd.w_rd = 1'b1;
			cts_pkg::ST_W_WAIT: cmd.w_div_start = 1'b1;
			cts_pkg::ST_W_DIV: cmd.w_div_start = 1'b0;
			cts_pkg::ST_W_WR: cmd.w_wr = !status.unit_busy;
			cts_pkg::ST_DIAG_DIV: cmd.diag_div_start = 1'b1;
			cts_pkg::ST_DIAG_WR: cmd.diag_wr = !status.unit_busy;
			cts_pkg::ST_ROW_NEXT: cmd.row_next = 1'b1;
			cts_pkg::ST_Q_SUM_RD: cmd.q_init = 1'b1;
			cts_pkg::ST_Q_SUM_ACC: cmd.q_sum_acc = 1'b1;
			cts_pkg::ST_Q_MUL: cmd.q_mul = 1'b1;
			cts_pkg::ST_Q_WALK_RD: cmd.q_rd = 1'b1;
			cts_pkg::ST_Q_WALK_CMP: cmd.q_walk_acc = 1'b1;
			cts_pkg::ST_DONE: cmd.done = 1'b1;
			default: cmd = '0;
		endcase
	end

	// a compute never runs its sqrt while the divider still works
	a_sqrt_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt_start |-> !status.unit_busy)
		else $error("sqrt started while a unit busy");
	// done lasts one cycle and returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cts_pkg::ST_DONE) |=> (state_q == cts_pkg::ST_IDLE))
		else $error("done did not return to idle");
	// a new transaction is only captured from idle
	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !busy)
		else $error("capture while busy");
endmodule

// File: src/cts_datapath.sv
// datapath: coordinate store, rmsd and weight tables, shared divider, square root
`timescale 1ns / 1ps
module cts_datapath #(
	parameter int MAX_CONFORMERS = 16,
	parameter int MAX_ATOMS = 4096,
	parameter int WEIGHT_FRACTION_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input cts_pkg::item_t item,
	input logic [4:0] conformer_count,
	input logic [12:0] atom_count,
	input cts_pkg::cmd_t cmd,
	output cts_pkg::status_t status,
	output cts_pkg::result_t result
);
	localparam int COORD_WIDTH = cts_pkg::CoordW;
	localparam int CIdxW = $clog2(MAX_CONFORMERS);
	localparam int AIdxW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int CCntW = $clog2(MAX_CONFORMERS + 1);
	localparam int ACntW = $clog2(MAX_ATOMS + 1);
	localparam int CoordDepth = MAX_CONFORMERS * MAX_ATOMS;
	localparam int CoordAW = $clog2(CoordDepth);
	localparam int PairDepth = MAX_CONFORMERS * MAX_CONFORMERS;
	localparam int PairAW = 2 * CIdxW;
	localparam int WW = WEIGHT_FRACTION_BITS + 1;
	localparam int DiffW = COORD_WIDTH + 1;
	localparam int RowW = WW + CIdxW + 1;
	localparam logic [63:0] NumConst = 64'd1 << (WEIGHT_FRACTION_BITS + 8);

	// captured transaction
	cts_pkg::item_t item_q;
	logic [CCntW-1:0] n_q;
	logic [ACntW-1:0] na_q;
	logic [CCntW-1:0] n_clamp;
	logic [ACntW-1:0] na_clamp;

	always_comb begin
		if (conformer_count == '0) begin
			n_clamp = CCntW'(1);
		end else if (32'(conformer_count) > MAX_CONFORMERS) begin
			n_clamp = CCntW'(MAX_CONFORMERS);
		end else begin
			n_clamp = CCntW'(conformer_count);
		end
		if (atom_count == '0) begin
			na_clamp = ACntW'(1);
		end else if (32'(atom_count) > MAX_ATOMS) begin
			na_clamp = ACntW'(MAX_ATOMS);
		end else begin
			na_clamp = ACntW'(atom_count);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
			n_q <= n_clamp;
			na_q <= na_clamp;
		end
	end

	// pair, atom and axis counters
	logic [CIdxW-1:0] ci_q, cj_q;
	logic [AIdxW-1:0] atom_q;
	logic [1:0] axis_q;
	logic rd_sel_q;
	logic atom_wait_q;
	logic [63:0] sd_q;
	logic load_ok;

	assign load_ok = (32'(item_q.load_conformer) < MAX_CONFORMERS) &&
		(32'(item_q.load_atom) < MAX_ATOMS);

	// coordinate memory, a single store read in turn for both conformers of the pair
	logic [CoordAW-1:0] coord_addr;
	logic [3*COORD_WIDTH-1:0] coord_wdata, coord_rdata;
	logic [3*COORD_WIDTH-1:0] coord_i_q;
	logic coord_we;

	assign coord_we = cmd.load_wr && load_ok;
	assign coord_wdata = {item_q.pos_x[COORD_WIDTH-1:0], item_q.pos_y[COORD_WIDTH-1:0],
		item_q.pos_z[COORD_WIDTH-1:0]};

	always_comb begin
		if (cmd.load_wr) begin
			coord_addr = CoordAW'(32'(item_q.load_conformer) * MAX_ATOMS
				+ 32'(item_q.load_atom));
		end else if (!rd_sel_q) begin
			coord_addr = CoordAW'(32'(ci_q) * MAX_ATOMS + 32'(atom_q));
		end else begin
			coord_addr = CoordAW'(32'(cj_q) * MAX_ATOMS + 32'(atom_q));
		end
	end

	cts_ram #(.WIDTH(3 * COORD_WIDTH), .DEPTH(CoordDepth)) u_coord (
		.clk(clk), .we(coord_we), .addr(coord_addr), .wdata(coord_wdata),
		.rdata(coord_rdata)
	);

	// squared difference of one axis
	logic signed [COORD_WIDTH-1:0] ca, cb;
	logic signed [DiffW-1:0] diff;
	logic [DiffW-1:0] mag;
	logic [2*DiffW-1:0] sq;
	logic [64:0] sd_sum;

	always_comb begin
		case (axis_q)
			2'd0: begin
				ca = coord_i_q[3*COORD_WIDTH-1:2*COORD_WIDTH];
				cb = coord_rdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
			end
			2'd1: begin
				ca = coord_i_q[2*COORD_WIDTH-1:COORD_WIDTH];
				cb = coord_rdata[2*COORD_WIDTH-1:COORD_WIDTH];
			end
			default: begin
				ca = coord_i_q[COORD_WIDTH-1:0];
				cb = coord_rdata[COORD_WIDTH-1:0];
			end
		endcase
		diff = DiffW'(ca) - DiffW'(cb);
		mag = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
		sq = mag * mag;
		sd_sum = {1'b0, sd_q} + 65'(sq);
	end

	// divider shared by all divisions, and the square root
	logic div_start;
	logic [63:0] div_a, div_b, div_q;
	logic div_busy, sqrt_busy;
	logic [31:0] root;
	logic [63:0] rowsum_q;

	logic [31:0] rmsd_rdata;

	always_comb begin
		div_start = cmd.div_start || cmd.w_div_start || cmd.diag_div_start;
		if (cmd.div_start) begin
			div_a = sd_q;
			div_b = 64'(na_q);
		end else if (cmd.w_div_start) begin
			div_a = NumConst + ((64'(rmsd_rdata) + 64'd256) >> 1);
			div_b = 64'(rmsd_rdata) + 64'd256;
		end else begin
			div_a = rowsum_q + 64'((n_q - 1'b1) >> 1);
			div_b = 64'(n_q - 1'b1);
		end
	end

	cts_divider #(.W(64)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .busy(div_busy), .quotient(div_q)
	);

	cts_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_start), .radicand(div_q),
		.busy(sqrt_busy), .root(root)
	);

	// rmsd table, written for both orders of the pair
	logic [PairAW-1:0] rmsd_addr;
	logic rmsd_we;
	logic rmsd_second_q;
	logic [CIdxW-1:0] wr_q, wc_q;

	assign rmsd_we = cmd.rmsd_wr || (rmsd_second_q);
	always_comb begin
		if (cmd.rmsd_wr) begin
			rmsd_addr = {ci_q, cj_q};
		end else if (rmsd_second_q) begin
			rmsd_addr = {cj_q, ci_q};
		end else begin
			rmsd_addr = {wr_q, wc_q};
		end
	end

	cts_ram #(.WIDTH(32), .DEPTH(PairDepth)) u_rmsd (
		.clk(clk), .we(rmsd_we), .addr(rmsd_addr), .wdata(root), .rdata(rmsd_rdata)
	);

	// weight table
	logic [PairAW-1:0] w_addr;
	logic w_we;
	logic [WW-1:0] w_wdata, w_rdata;
	logic [CIdxW-1:0] qc_q;
	logic [CIdxW-1:0] qrow;
	logic [CCntW-1:0] cur_m1;

	assign cur_m1 = CCntW'(item_q.current_conformer - 5'd1);
	assign qrow = cur_m1[CIdxW-1:0];
	assign w_we = cmd.w_wr || cmd.diag_wr;
	always_comb begin
		if (cmd.w_wr) begin
			w_addr = {wr_q, wc_q};
			w_wdata = WW'(div_q);
		end else if (cmd.diag_wr) begin
			w_addr = {wr_q, wr_q};
			w_wdata = status.single ? WW'(1 << WEIGHT_FRACTION_BITS) : WW'(div_q);
		end else begin
			// the first read of a query row starts at column zero
			w_addr = {qrow, cmd.q_init ? CIdxW'(0) : qc_q};
			w_wdata = WW'(div_q);
		end
	end

	cts_ram #(.WIDTH(WW), .DEPTH(PairDepth)) u_weight (
		.clk(clk), .we(w_we), .addr(w_addr), .wdata(w_wdata), .rdata(w_rdata)
	);

	// query accumulators
	logic [RowW-1:0] qsum_q, qacc_q, qacc_new;
	logic [RowW+15:0] thr_q;
	logic q_rd_valid_q;
	logic [CIdxW-1:0] qk_q;
	logic [4:0] next_q;

	assign qacc_new = qacc_q + RowW'(w_rdata);

	// sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmsd_second_q <= 1'b0;
			rd_sel_q <= 1'b0;
			atom_wait_q <= 1'b0;
			q_rd_valid_q <= 1'b0;
		end else begin
			rmsd_second_q <= cmd.rmsd_wr;
			// second conformer stays addressed until the atom's last axis
			if (cmd.atom_rd) begin
				rd_sel_q <= 1'b1;
			end else if (cmd.axis_acc && (axis_q == 2'd2)) begin
				rd_sel_q <= 1'b0;
			end
			atom_wait_q <= cmd.atom_rd;
			q_rd_valid_q <= cmd.q_init || cmd.q_sum_acc;
		end
	end

	// compute side counters and sums
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ci_q <= '0;
			cj_q <= CIdxW'(1);
			wr_q <= '0;
			wc_q <= CIdxW'(1);
		end
		if (cmd.pair_init) begin
			atom_q <= '0;
			axis_q <= '0;
			sd_q <= '0;
		end
		// first conformer's atom is captured from the registered read of the coordinate store
		if (atom_wait_q) begin
			coord_i_q <= coord_rdata;
		end
		if (cmd.axis_acc) begin
			sd_q <= sd_sum[64] ? '1 : sd_sum[63:0];
			if (axis_q == 2'd2) begin
				axis_q <= '0;
				atom_q <= atom_q + 1'b1;
			end else begin
				axis_q <= axis_q + 1'b1;
			end
		end
		if (cmd.pair_next) begin
			if (32'(cj_q) + 1 >= 32'(n_q)) begin
				ci_q <= ci_q + 1'b1;
				cj_q <= ci_q + CIdxW'(2);
			end else begin
				cj_q <= cj_q + 1'b1;
			end
		end
		// row sum restarts at the first off-diagonal column of the row
		if (cmd.w_rd) begin
			if (wc_q == ((wr_q == '0) ? CIdxW'(1) : CIdxW'(0))) begin
				rowsum_q <= '0;
			end
		end
		if (cmd.w_wr) begin
			rowsum_q <= rowsum_q + 64'(div_q[WW-1:0]);
			wc_q <= (wc_q + 1'b1 == wr_q) ? wc_q + CIdxW'(2) : wc_q + 1'b1;
		end
		if (cmd.row_next) begin
			wr_q <= wr_q + 1'b1;
			wc_q <= '0;
		end
		// query
		if (cmd.q_init) begin
			qc_q <= CIdxW'(1);
			qk_q <= '0;
			qsum_q <= '0;
			qacc_q <= '0;
			next_q <= '0;
		end
		if (cmd.q_sum_acc) begin
			qsum_q <= qsum_q + RowW'(w_rdata);
			qc_q <= qc_q + 1'b1;
		end
		if (cmd.q_mul) begin
			thr_q <= qsum_q * item_q.random_fraction;
			qc_q <= '0;
		end
		if (cmd.q_rd) begin
			qc_q <= qc_q + 1'b1;
		end
		if (cmd.q_walk_acc) begin
			qacc_q <= qacc_new;
			qk_q <= qk_q + 1'b1;
			qc_q <= qc_q + 1'b1;
			if (status.q_hit) begin
				next_q <= 5'(qk_q) + 5'd1;
			end else if (status.q_col_last) begin
				next_q <= 5'(n_q);
			end
		end
	end

	// count of columns summed in the sum pass; the read address runs a column ahead of it
	logic [CIdxW-1:0] qsum_k_q;
	always_ff @(posedge clk) begin
		if (cmd.q_init) begin
			qsum_k_q <= '0;
		end else if (cmd.q_sum_acc) begin
			qsum_k_q <= qsum_k_q + 1'b1;
		end
	end

	// status to the controller
	always_comb begin
		status = '0;
		status.axis_last = (axis_q == 2'd2);
		status.atom_last = (32'(atom_q) + 1 >= 32'(na_q));
		status.pair_last = (32'(ci_q) + 1 >= 32'(n_q));
		status.unit_busy = div_busy || sqrt_busy;
		status.single = (n_q == CCntW'(1));
		status.col_last = (32'(wc_q) + 1 >= 32'(n_q)) ||
			((32'(wc_q) + 2 >= 32'(n_q)) && (32'(wc_q) + 1 == 32'(wr_q)));
		status.row_last = (32'(wr_q) + 1 >= 32'(n_q));
		status.q_bad = (item_q.current_conformer == '0) ||
			(32'(item_q.current_conformer) > 32'(n_q));
		status.q_col_last = cmd.q_sum_acc ? (32'(qsum_k_q) + 1 >= 32'(n_q))
			: (32'(qk_q) + 1 >= 32'(n_q));
		status.q_hit = ({qacc_new, 16'd0} > (RowW+16)'(thr_q));
	end

	// result formation
	always_comb begin
		result = '0;
		case (item_q.operation)
			cts_pkg::OP_COMPUTE: result.result_kind = cts_pkg::KIND_COMPUTE;
			cts_pkg::OP_QUERY: begin
				result.result_kind = cts_pkg::KIND_QUERY;
				result.next_conformer = status.q_bad ? 5'd0 : next_q;
			end
			default: result = '0;
		endcase
	end

	// the saturating sum never falls while a pair accumulates
	a_sd_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.axis_acc |=> (sd_q >= $past(sd_q)))
		else $error("distance sum decreased");
	// the second rmsd write follows the first
	a_rmsd_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rmsd_wr |=> rmsd_second_q)
		else $error("mirror rmsd write missing");
	// the walk accumulator never passes the row sum
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.q_walk_acc |-> (qacc_new <= qsum_q))
		else $error("walk passed row sum");
endmodule
